>>> design/bkn_pkg.sv
`default_nettype none
package bkn_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned KeyCount     = 24;

  localparam logic [15:0] PressureStartReset  = 16'd1000;
  localparam logic [15:0] PressureMaxReset    = 16'd3000;
  localparam logic [15:0] LevelThresholdReset = 16'd6554;
  localparam logic [3:0]  MidiChannelReset    = 4'd0;

  localparam logic [31:0] CtrlNextKeys = 32'd65536;
  localparam logic [31:0] CtrlPrevKeys = 32'd4194304;
  localparam logic [31:0] CtrlOffKeys  = 32'd524288;

  localparam logic [6:0] VelocityOn    = 7'd100;
  localparam logic [3:0] StatusNoteOff = 4'h8;
  localparam logic [3:0] StatusNoteOn  = 4'h9;

  typedef enum logic [1:0] {
    REG_PRESSURE_START  = 2'd0,
    REG_PRESSURE_MAX    = 2'd1,
    REG_LEVEL_THRESHOLD = 2'd2,
    REG_MIDI_CHANNEL    = 2'd3
  } reg_e;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_CTRL,
    KIND_SAMPLE
  } kind_e;

  typedef enum logic [1:0] {
    CTRL_NONE = 2'd0,
    CTRL_NEXT = 2'd1,
    CTRL_PREV = 2'd2,
    CTRL_OFF  = 2'd3
  } ctrl_e;

  typedef enum logic [2:0] {
    EV_CONTROL   = 3'd0,
    EV_LEVEL     = 3'd1,
    EV_NOTE_OFF  = 3'd2,
    EV_NOTE_ON   = 3'd3,
    EV_LOAD_DONE = 3'd4
  } event_e;

  typedef struct packed {
    logic [15:0] pressure_start;
    logic [15:0] pressure_max;
    logic [15:0] level_threshold;
    logic [3:0]  midi_channel;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    ctrl_e       code;
    logic [15:0] pressure;
    logic [23:0] key;
    logic [9:0]  index;
    logic [6:0]  note;
    logic        enable;
  } item_t;

endpackage
`default_nettype wire

>>> design/bkn_if.sv
`default_nettype none
interface bkn_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  command;
  logic [15:0] pressure_raw;
  logic [23:0] key_word;
  logic [9:0]  entry_index;
  logic [6:0]  entry_note;
  logic        entry_enable;

  modport source (output valid, command, pressure_raw, key_word, entry_index, entry_note,
                  entry_enable, input ready);
  modport sink (input valid, command, pressure_raw, key_word, entry_index, entry_note,
                entry_enable, output ready);
endinterface

interface bkn_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  midi_status;
  logic [6:0]  note_number;
  logic [6:0]  velocity;
  logic [15:0] level;
  logic [1:0]  control_code;
  logic        last;

  modport source (output valid, event_res, midi_status, note_number, velocity, level,
                  control_code, last, input ready);
  modport sink (input valid, event_res, midi_status, note_number, velocity, level,
                control_code, last, output ready);
endinterface
`default_nettype wire

>>> design/bkn_front.sv
`default_nettype none
module bkn_front #(
  parameter int unsigned KEY_COUNT = bkn_pkg::KeyCount
) (
  bkn_in_if.sink          in_i,
  input  wire bkn_pkg::cfg_t cfg_i,
  input  wire             clearing_i,
  input  wire             full_i,
  output logic            push_o,
  output bkn_pkg::item_t  item_o
);

  logic [19:0] p_times_10;
  logic [19:0] start_times_9;
  logic [31:0] keys;

  assign in_i.ready = !full_i && !clearing_i;
  assign push_o     = in_i.valid && in_i.ready;

  // Control gestures compare against 90% of the start pressure without a divide.
  assign p_times_10    = 20'(in_i.pressure_raw) * 20'd10;
  assign start_times_9 = 20'(cfg_i.pressure_start) * 20'd9;
  assign keys          = 32'(KEY_COUNT'(in_i.key_word));

  always_comb begin
    item_o.pressure = in_i.pressure_raw;
    item_o.key      = in_i.key_word;
    item_o.index    = in_i.entry_index;
    item_o.note     = in_i.entry_note;
    item_o.enable   = in_i.entry_enable;
    item_o.code     = bkn_pkg::CTRL_NONE;
    if (in_i.command == bkn_pkg::CMD_LOAD) begin
      item_o.kind = bkn_pkg::KIND_LOAD;
    end else if (p_times_10 < start_times_9) begin
      item_o.kind = bkn_pkg::KIND_CTRL;
      if (keys == bkn_pkg::CtrlNextKeys) begin
        item_o.code = bkn_pkg::CTRL_NEXT;
      end else if (keys == bkn_pkg::CtrlPrevKeys) begin
        item_o.code = bkn_pkg::CTRL_PREV;
      end else if (keys == bkn_pkg::CtrlOffKeys) begin
        item_o.code = bkn_pkg::CTRL_OFF;
      end
    end else begin
      item_o.kind = bkn_pkg::KIND_SAMPLE;
    end
  end

endmodule
`default_nettype wire

>>> design/bkn_fifo.sv
`default_nettype none
module bkn_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wire bkn_pkg::item_t item_i,
  input  wire            pop_i,
  output bkn_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);

  bkn_pkg::item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/bkn_back.sv
`default_nettype none
module bkn_back #(
  parameter int unsigned TABLE_ENTRIES = bkn_pkg::TableEntries,
  parameter int unsigned KEY_COUNT     = bkn_pkg::KeyCount
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire bkn_pkg::cfg_t  cfg_i,
  input  wire bkn_pkg::item_t item_i,
  input  wire                 empty_i,
  output logic                pop_o,
  output logic                clearing_o,
  bkn_out_if.source           out_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned WordW = 1 + KEY_COUNT + 7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SQRT,
    S_SEARCH,
    S_EMIT
  } state_e;

  state_e state_q;
  logic [IdxW:0] cnt_q;
  logic [3:0]    step_q;

  logic [WordW-1:0] table_mem [TABLE_ENTRIES];
  logic [WordW-1:0] rd_word_q;
  logic             rd_valid_q;

  logic [15:0] div_rem_q, div_b_q, quo_q;
  logic        a_eq_b_q;
  logic [31:0] v_q;
  logic [16:0] sq_rem_q;
  logic [15:0] root_q;

  logic [KEY_COUNT-1:0] key_q;
  logic [15:0] prev_level_q;
  logic [6:0]  held_note_q, off_note_q, on_note_q;
  logic        held_q;
  logic        pend_simple_q, pend_lvl_q, pend_off_q, pend_on_q;
  bkn_pkg::event_e simple_ev_q;
  bkn_pkg::ctrl_e  simple_code_q;

  logic        out_valid_q, out_last_q;
  bkn_pkg::event_e out_ev_q;
  logic [7:0]  out_status_q;
  logic [6:0]  out_note_q, out_vel_q;
  logic [15:0] out_level_q;
  logic [1:0]  out_code_q;

  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             in_range, match;
  logic [16:0]      div_t;
  logic             div_bit;
  logic [15:0]      norm;
  logic [18:0]      sq_r2, sq_trial;
  logic             sq_bit;
  logic [15:0]      level;
  logic [15:0]      clamp_p;

  assign pop_o      = (state_q == S_IDLE) && !empty_i;
  assign clearing_o = state_q == S_CLEAR;
  assign in_range   = 32'(item_i.index) < 32'(TABLE_ENTRIES);
  assign mem_re     = (state_q == S_SEARCH) && (32'(cnt_q) < 32'(TABLE_ENTRIES));
  assign match      = rd_word_q[WordW-1] && (rd_word_q[KEY_COUNT+6:7] == key_q);

  assign div_t   = {div_rem_q, 1'b0};
  assign div_bit = div_t >= {1'b0, div_b_q};
  assign norm    = a_eq_b_q ? 16'hFFFF : {quo_q[14:0], div_bit};

  assign sq_r2    = {sq_rem_q, v_q[31:30]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_bit   = sq_r2 >= sq_trial;
  assign level    = {root_q[14:0], sq_bit};

  assign clamp_p = (item_i.pressure > cfg_i.pressure_max) ? cfg_i.pressure_max
                                                           : item_i.pressure;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[IdxW-1:0];
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (pop_o && item_i.kind == bkn_pkg::KIND_LOAD && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = IdxW'(item_i.index);
      mem_wdata = {item_i.enable, KEY_COUNT'(item_i.key), item_i.note};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word_q <= table_mem[cnt_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_o && item_i.kind == bkn_pkg::KIND_SAMPLE) begin
          key_q    <= KEY_COUNT'(item_i.key);
          sq_rem_q <= '0;
          root_q   <= '0;
          quo_q    <= '0;
          div_rem_q <= clamp_p - cfg_i.pressure_start;
          div_b_q   <= cfg_i.pressure_max - cfg_i.pressure_start;
          a_eq_b_q  <= (clamp_p - cfg_i.pressure_start) ==
                       (cfg_i.pressure_max - cfg_i.pressure_start);
          if (item_i.pressure <= cfg_i.pressure_start) begin
            v_q <= '0;
          end else begin
            v_q <= {16'hFFFF, 16'h0000};
          end
        end
      end
      S_DIV: begin
        div_rem_q <= div_bit ? 16'(div_t - {1'b0, div_b_q}) : div_t[15:0];
        quo_q     <= {quo_q[14:0], div_bit};
        if (step_q == 4'd15) begin
          v_q <= {norm, 16'h0000};
        end
      end
      S_SQRT: begin
        sq_rem_q <= sq_bit ? 17'(sq_r2 - sq_trial) : sq_r2[16:0];
        root_q   <= level;
        v_q      <= {v_q[29:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      cnt_q         <= '0;
      step_q        <= '0;
      rd_valid_q    <= 1'b0;
      prev_level_q  <= '0;
      held_note_q   <= '0;
      held_q        <= 1'b0;
      off_note_q    <= '0;
      on_note_q     <= '0;
      pend_simple_q <= 1'b0;
      pend_lvl_q    <= 1'b0;
      pend_off_q    <= 1'b0;
      pend_on_q     <= 1'b0;
      simple_ev_q   <= bkn_pkg::EV_CONTROL;
      simple_code_q <= bkn_pkg::CTRL_NONE;
      out_valid_q   <= 1'b0;
      out_last_q    <= 1'b0;
      out_ev_q      <= bkn_pkg::EV_CONTROL;
      out_status_q  <= '0;
      out_note_q    <= '0;
      out_vel_q     <= '0;
      out_level_q   <= '0;
      out_code_q    <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (32'(cnt_q) == 32'(TABLE_ENTRIES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            step_q <= '0;
            case (item_i.kind)
              bkn_pkg::KIND_LOAD: begin
                pend_simple_q <= 1'b1;
                simple_ev_q   <= bkn_pkg::EV_LOAD_DONE;
                simple_code_q <= bkn_pkg::CTRL_NONE;
                state_q       <= S_EMIT;
              end
              bkn_pkg::KIND_CTRL: begin
                pend_simple_q <= 1'b1;
                simple_ev_q   <= bkn_pkg::EV_CONTROL;
                simple_code_q <= item_i.code;
                state_q       <= S_EMIT;
              end
              default: begin
                if (item_i.pressure > cfg_i.pressure_start &&
                    cfg_i.pressure_max > cfg_i.pressure_start) begin
                  state_q <= S_DIV;
                end else begin
                  state_q <= S_SQRT;
                end
              end
            endcase
          end
        end
        S_DIV: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            pend_lvl_q   <= level != prev_level_q;
            prev_level_q <= level;
            if (level >= cfg_i.level_threshold) begin
              cnt_q      <= '0;
              rd_valid_q <= 1'b0;
              state_q    <= S_SEARCH;
            end else begin
              if (held_q) begin
                pend_off_q  <= 1'b1;
                off_note_q  <= held_note_q;
                held_note_q <= '0;
                held_q      <= 1'b0;
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_SEARCH: begin
          rd_valid_q <= mem_re;
          if (mem_re) begin
            cnt_q <= cnt_q + 1'b1;
          end
          // The first valid match is the lowest slot, since slots are read in order.
          if (rd_valid_q && match) begin
            if (!(held_q && held_note_q == rd_word_q[6:0])) begin
              if (held_q) begin
                pend_off_q <= 1'b1;
                off_note_q <= held_note_q;
              end
              pend_on_q   <= 1'b1;
              on_note_q   <= rd_word_q[6:0];
              held_note_q <= rd_word_q[6:0];
              held_q      <= 1'b1;
            end
            state_q <= S_EMIT;
          end else if (rd_valid_q && !mem_re) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_level_q  <= prev_level_q;
            out_status_q <= '0;
            out_note_q   <= '0;
            out_vel_q    <= '0;
            out_code_q   <= bkn_pkg::CTRL_NONE;
            if (pend_simple_q) begin
              pend_simple_q <= 1'b0;
              out_valid_q   <= 1'b1;
              out_ev_q      <= simple_ev_q;
              out_code_q    <= simple_code_q;
              out_last_q    <= 1'b1;
            end else if (pend_lvl_q) begin
              pend_lvl_q  <= 1'b0;
              out_valid_q <= 1'b1;
              out_ev_q    <= bkn_pkg::EV_LEVEL;
              out_last_q  <= !(pend_off_q || pend_on_q);
            end else if (pend_off_q) begin
              pend_off_q   <= 1'b0;
              out_valid_q  <= 1'b1;
              out_ev_q     <= bkn_pkg::EV_NOTE_OFF;
              out_status_q <= {bkn_pkg::StatusNoteOff, cfg_i.midi_channel};
              out_note_q   <= off_note_q;
              out_last_q   <= !pend_on_q;
            end else if (pend_on_q) begin
              pend_on_q    <= 1'b0;
              out_valid_q  <= 1'b1;
              out_ev_q     <= bkn_pkg::EV_NOTE_ON;
              out_status_q <= {bkn_pkg::StatusNoteOn, cfg_i.midi_channel};
              out_note_q   <= on_note_q;
              out_vel_q    <= bkn_pkg::VelocityOn;
              out_last_q   <= 1'b1;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = out_ev_q;
  assign out_o.midi_status  = out_status_q;
  assign out_o.note_number  = out_note_q;
  assign out_o.velocity     = out_vel_q;
  assign out_o.level        = out_level_q;
  assign out_o.control_code = out_code_q;
  assign out_o.last         = out_last_q;

endmodule
`default_nettype wire

>>> design/breath_key_note_controller_unit.sv
// Breath and key wind-controller core.
// Requests arrive on in_i: a sample (pressure and key word) or a note table load.
// Results leave on out_o, zero to three per request, the final one marked by last.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while idle, which the block itself does not enforce.
// After reset the note table is swept clear, one slot a cycle, over every slot;
// in_i.ready stays low during that sweep. A load or a control gesture gives a
// single result, set in the output register from the back's emit state.
// A sample runs a divider, skipped when the pressure or the configured maximum
// does not exceed the start pressure, and a square root unit; at or above the
// level threshold it scans the table via its one read port, one slot a cycle.
// A two-entry queue sits between the classifying front and the executing back,
// so the next request is taken while the back is busy. Results are held in an
// output register; when the receiver stalls the back waits, the queue fills,
// and then in_i.ready drops.
`default_nettype none
module breath_key_note_controller_unit #(
  parameter int unsigned TABLE_ENTRIES = bkn_pkg::TableEntries,
  parameter int unsigned KEY_COUNT     = bkn_pkg::KeyCount
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [15:0] cfg_data_i,
  bkn_in_if.sink     in_i,
  bkn_out_if.source  out_o
);

  bkn_pkg::cfg_t  cfg_q;
  bkn_pkg::item_t push_item, head_item;
  logic push, pop, full, empty, clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure_start  <= bkn_pkg::PressureStartReset;
      cfg_q.pressure_max    <= bkn_pkg::PressureMaxReset;
      cfg_q.level_threshold <= bkn_pkg::LevelThresholdReset;
      cfg_q.midi_channel    <= bkn_pkg::MidiChannelReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bkn_pkg::REG_PRESSURE_START:  cfg_q.pressure_start  <= cfg_data_i;
        bkn_pkg::REG_PRESSURE_MAX:    cfg_q.pressure_max    <= cfg_data_i;
        bkn_pkg::REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= cfg_data_i;
        default:                      cfg_q.midi_channel    <= cfg_data_i[3:0];
      endcase
    end
  end

  bkn_front #(.KEY_COUNT(KEY_COUNT)) u_front (
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .clearing_i (clearing),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  bkn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  bkn_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_COUNT(KEY_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (head_item),
    .empty_i    (empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire
